### design/sqi_pkg.sv
// ----------------------------------------------------------------------------
// Sorted insertion queue package
// Request and result item types, request and status codes, and the
// command that the sequencer broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package sqi_pkg;

  // Request codes carried in an input item.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LIST   = 2'd2,
    REQ_ROTATE = 2'd3
  } sqi_req_e;

  // Status codes carried in a result item.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } sqi_status_e;

  // Operation that every cell performs.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } sqi_op_e;

  // Input item.
  typedef struct packed {
    sqi_req_e           req_type;
    logic signed [31:0] value;
    logic [3:0]         start_index;
  } sqi_req_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] item;
    sqi_status_e        status;
    logic               last;
  } sqi_rsp_t;

  // Command broadcast to all cells.
  typedef struct packed {
    sqi_op_e            op;
    logic signed [31:0] value;
    logic signed [31:0] head;
  } sqi_cell_ctl_t;

endpackage

### design/sqi_cell.sv
// ----------------------------------------------------------------------------
// Sorted insertion queue storage cell
// Holds one stored value. Compares it against the broadcast insert value
// and takes its own value, its left or its right neighbor's value, the insert
// value or the broadcast head value as the command demands.
// ----------------------------------------------------------------------------
module sqi_cell
  import sqi_pkg::*;
(
  input  logic               clk_i,
  input  sqi_cell_ctl_t      ctl_i,
  input  logic               occupied_i,
  input  logic               tail_i,
  input  logic               left_ge_i,
  input  logic signed [31:0] left_data_i,
  input  logic signed [31:0] right_data_i,
  output logic signed [31:0] entry_o,
  output logic               ge_o
);

  logic signed [31:0] entry_q, entry_d;

  // The cell sits at or past the insert position when it is empty or its
  // value is greater than or equal to the new value.
  assign ge_o = !occupied_i || !($signed(entry_q) < $signed(ctl_i.value));

  // Next value of the cell.
  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (ge_o) begin
          entry_d = left_ge_i ? left_data_i : ctl_i.value;
        end
      end
      OP_REMOVE: begin
        entry_d = right_data_i;
      end
      OP_ROTATE: begin
        entry_d = tail_i ? ctl_i.head : right_data_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### design/sorted_insertion_queue.sv
// ----------------------------------------------------------------------------
// Sorted insertion queue
// Keeps up to SLOTS signed values in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// An insert or a remove keeps busy low, and its single result item appears on
// rsp_o with rsp_valid_o high in the next cycle. Error and empty replies also
// appear in the next cycle. A list request rotates the whole row once, one
// position per cycle, holding busy while it walks, and emits one item per cycle.
// A rotate request walks the row around twice so that the stored order comes
// back intact, holding busy while it walks; its items come out one per cycle
// from the start position onward. The receiver cannot stall the block: every
// result item is on the result port for exactly one cycle, and the final item
// of each request has last set.
// ----------------------------------------------------------------------------
module sorted_insertion_queue
  import sqi_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sqi_req_t req_i,
  output logic     rsp_valid_o,
  output sqi_rsp_t rsp_o
);

  localparam int FW = $clog2(SLOTS + 1);
  localparam int KW = $clog2(2 * SLOTS);
  localparam int SW = (FW > 4) ? FW : 4;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } sqi_state_e;

  sqi_state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] start_q, start_d;
  logic [KW-1:0] win_end_q, win_end_d;
  logic [KW-1:0] end_q, end_d;
  logic          rot_q, rot_d;
  logic          emit_q, emit_d;
  logic signed [31:0] first_q, first_d;
  logic          rsp_valid_q, rsp_valid_d;
  sqi_rsp_t      rsp_q, rsp_d;

  sqi_cell_ctl_t      ctl;
  logic signed [31:0] entry [SLOTS];
  logic               ge [SLOTS];

  logic          accept;
  logic          walk_req;
  logic          range_err;
  logic [KW-1:0] fill_k;
  logic          active;
  logic          is_last;
  logic signed [31:0] cmp_val;

  assign accept    = start && !busy;
  assign fill_k    = KW'(fill_q);
  assign range_err = SW'(req_i.start_index) >= SW'(fill_q);
  assign walk_req  = (fill_q != '0) &&
                     ((req_i.req_type == REQ_LIST) ||
                      ((req_i.req_type == REQ_ROTATE) && !range_err));

  // Row of storage cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic               left_ge;
    logic signed [31:0] left_data;
    logic signed [31:0] right_data;

    if (i == 0) begin : g_first
      assign left_ge   = 1'b0;
      assign left_data = ctl.value;
    end else begin : g_mid
      assign left_ge   = ge[i-1];
      assign left_data = entry[i-1];
    end

    if (i == SLOTS - 1) begin : g_end
      assign right_data = entry[i];
    end else begin : g_inner
      assign right_data = entry[i+1];
    end

    sqi_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occupied_i   (FW'(i) < fill_q),
      .tail_i       (FW'(i) == fill_q - FW'(1)),
      .left_ge_i    (left_ge),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .entry_o      (entry[i]),
      .ge_o         (ge[i])
    );
  end

  // During a walk the head cell shows the entry at step k modulo fill.
  assign active  = emit_q && (k_q >= start_q);
  assign cmp_val = (k_q == start_q) ? entry[0] : first_q;
  assign is_last = (k_q == win_end_q) || (rot_q && (entry[1] == cmp_val));

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    k_d         = k_q;
    start_d     = start_q;
    win_end_d   = win_end_q;
    end_d       = end_q;
    rot_d       = rot_q;
    emit_d      = emit_q;
    first_d     = first_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    ctl.op      = OP_HOLD;
    ctl.value   = req_i.value;
    ctl.head    = entry[0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_valid_d = !walk_req;
          rsp_d.item   = '0;
          rsp_d.status = STAT_OK;
          rsp_d.last   = 1'b1;
          case (req_i.req_type)
            REQ_INSERT: begin
              if (fill_q == FW'(SLOTS)) begin
                rsp_d.status = STAT_FULL;
              end else begin
                ctl.op     = OP_INSERT;
                fill_d     = fill_q + FW'(1);
                rsp_d.item = req_i.value;
              end
            end
            REQ_REMOVE: begin
              if (fill_q == '0) begin
                rsp_d.status = STAT_EMPTY;
              end else begin
                ctl.op     = OP_REMOVE;
                fill_d     = fill_q - FW'(1);
                rsp_d.item = entry[0];
              end
            end
            REQ_LIST, REQ_ROTATE: begin
              if (fill_q == '0) begin
                rsp_d.status = STAT_EMPTY;
              end else if (walk_req) begin
                state_d = S_WALK;
                k_d     = '0;
                emit_d  = 1'b1;
                if (req_i.req_type == REQ_LIST) begin
                  rot_d     = 1'b0;
                  start_d   = '0;
                  win_end_d = fill_k - KW'(1);
                  end_d     = fill_k - KW'(1);
                end else begin
                  rot_d     = 1'b1;
                  start_d   = KW'(req_i.start_index);
                  win_end_d = KW'(req_i.start_index) + fill_k - KW'(1);
                  end_d     = (fill_k << 1) - KW'(1);
                end
              end else begin
                rsp_d.status = STAT_RANGE;
              end
            end
            default: begin
              rsp_valid_d = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        ctl.op = OP_ROTATE;
        k_d    = k_q + KW'(1);
        if (k_q == start_q) begin
          first_d = entry[0];
        end
        if (active) begin
          rsp_valid_d  = 1'b1;
          rsp_d.item   = entry[0];
          rsp_d.status = STAT_OK;
          rsp_d.last   = is_last;
          if (is_last) begin
            emit_d = 1'b0;
          end
        end
        if (k_q == end_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      k_q         <= '0;
      emit_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      k_q         <= k_d;
      emit_q      <= emit_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Walk bounds and result payload.
  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    win_end_q <= win_end_d;
    end_q     <= end_d;
    rot_q     <= rot_d;
    first_q   <= first_d;
    rsp_q     <= rsp_d;
  end

  assign busy        = (state_q == S_WALK);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The count of stored values never exceeds the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FW'(SLOTS))
    else $error("fill count exceeds the number of cells");

  // A request that needs no walk answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !walk_req) |=> rsp_valid_o)
    else $error("single-result item got no reply");

  // A walk never changes the number of stored values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |=> (fill_q == $past(fill_q)))
    else $error("fill changed during a walk");

  // Emission has ended by the time the walk finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) && (k_q == end_q)) |-> (!emit_q || (k_q == win_end_q)))
    else $error("walk finished with items left to emit");

  // Each walk closes with a result that has last set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) && active && is_last) |=> (rsp_valid_o && rsp_o.last))
    else $error("final walk item lost its last mark");

endmodule
